// ===== rtl/ffcd_pkg.sv =====
// Shared types, character codes and decode helpers for the frame command decoder.
package ffcd_pkg;

  localparam int FRAME_LEN = 13;
  localparam int LEN_SAT   = 14;
  localparam int LEN_W     = $clog2(LEN_SAT + 1);
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int DIR_W     = 4;
  localparam int SPEED_W   = 11;
  localparam int QDEPTH    = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [DIR_W-1:0] DIR_EMPTY_LINE = 4'd5;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_IGNORE = 2'd2
  } line_status_t;

  // One classified line, handed from the front end to the executor.
  typedef struct packed {
    line_status_t              status;
    logic                      scan_set;
    logic                      scan_clr;
    logic                      motor_sel;
    logic [DIR_W-1:0]          dir;
    logic signed [SPEED_W-1:0] speed;
    logic                      restart;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // space, and TAB through CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // atol-style parse of a three-character field
  function automatic logic signed [SPEED_W-1:0] parse_speed(input logic [7:0] c0,
                                                            input logic [7:0] c1,
                                                            input logic [7:0] c2);
    logic [7:0] ch [3];
    logic       lead;
    logic       neg;
    logic       done;
    logic [9:0] v;
    logic [7:0] d;
    int         k;
    ch[0] = c0;
    ch[1] = c1;
    ch[2] = c2;
    lead  = 1'b1;
    neg   = 1'b0;
    done  = 1'b0;
    v     = '0;
    d     = '0;
    for (k = 0; k < 3; k++) begin
      if (!done) begin
        if (lead && is_space(ch[k])) begin
          lead = 1'b1;
        end else if (lead && ((ch[k] == CH_PLUS) || (ch[k] == CH_MINUS))) begin
          lead = 1'b0;
          neg  = (ch[k] == CH_MINUS);
        end else if (is_digit(ch[k])) begin
          lead = 1'b0;
          d    = ch[k] - CH_ZERO;
          v    = 10'(v * 10) + {6'b0, d[3:0]};
        end else begin
          done = 1'b1;
        end
      end
    end
    return neg ? -SPEED_W'({1'b0, v}) : SPEED_W'({1'b0, v});
  endfunction

endpackage

// ===== rtl/ffcd_front.sv =====
// Front end: gathers line bytes and classifies each finished line into a command.
module ffcd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 q_full,
  output logic                 push,
  output ffcd_pkg::cmd_t       push_cmd
);
  import ffcd_pkg::*;

  logic [7:0]       line_q [FRAME_LEN];
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic             accept;
  logic             is_lf;
  logic             frame_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_lf    = (rx_byte == CH_LF);
  assign push     = accept && is_lf;

  always_comb begin
    len_next = len;
    if (accept && (rx_byte != CH_CR)) begin
      if (is_lf) begin
        len_next = '0;
      end else if (len < LEN_W'(LEN_SAT)) begin
        len_next = len + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  // store has no reset; a line is accepted only once all entries were written
  always_ff @(posedge clk) begin
    if (accept && !is_lf && (rx_byte != CH_CR) && (len < LEN_W'(FRAME_LEN))) begin
      line_q[len[IDX_W-1:0]] <= rx_byte;
    end
  end

  assign frame_ok = (len == LEN_W'(FRAME_LEN)) && (line_q[0] == CH_ONE) &&
                    (line_q[1] == CH_ONE) && (line_q[2] == CH_ONE);

  always_comb begin
    push_cmd.status    = (len == '0) ? ST_EMPTY : (frame_ok ? ST_ACCEPT : ST_IGNORE);
    push_cmd.scan_set  = frame_ok && (line_q[3] == CH_ONE) && (line_q[4] == CH_ZERO) &&
                         (line_q[5] == CH_ZERO) && (line_q[6] == CH_ONE);
    push_cmd.scan_clr  = frame_ok && (line_q[3] == CH_ONE) && (line_q[4] == CH_ZERO) &&
                         (line_q[5] == CH_ZERO) && (line_q[6] == CH_ZERO);
    push_cmd.motor_sel = frame_ok && (line_q[7] == CH_TWO);
    push_cmd.dir       = is_digit(line_q[8]) ? DIR_W'(line_q[8] - CH_ZERO) : '0;
    push_cmd.speed     = parse_speed(line_q[9], line_q[10], line_q[11]);
    push_cmd.restart   = push_cmd.motor_sel && (line_q[12] == CH_ONE);
  end

endmodule

// ===== rtl/ffcd_queue.sv =====
// Short command FIFO between front end and executor.
module ffcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ffcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ffcd_pkg::cmd_t pop_cmd
);
  import ffcd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entry [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/ffcd_back.sv =====
// Executor: applies commands to the drive/scanner state and registers the result.
module ffcd_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  ffcd_pkg::cmd_t                       cmd,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           line_status,
  output logic                                 scan_active,
  output logic [ffcd_pkg::DIR_W-1:0]           drive_direction,
  output logic signed [ffcd_pkg::SPEED_W-1:0]  drive_speed,
  output logic                                 move_restart
);
  import ffcd_pkg::*;

  logic                      scan;
  logic [DIR_W-1:0]          dir;
  logic signed [SPEED_W-1:0] speed;
  logic                      scan_next;
  logic [DIR_W-1:0]          dir_next;
  logic signed [SPEED_W-1:0] speed_next;

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    scan_next  = scan;
    dir_next   = dir;
    speed_next = speed;
    unique case (cmd.status)
      ST_EMPTY: begin
        dir_next = DIR_EMPTY_LINE;
      end
      ST_ACCEPT: begin
        if (cmd.scan_set) begin
          scan_next = 1'b1;
        end else if (cmd.scan_clr) begin
          scan_next = 1'b0;
        end
        if (cmd.motor_sel) begin
          dir_next   = cmd.dir;
          speed_next = cmd.speed;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= 1'b0;
      dir       <= '0;
      speed     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        scan      <= scan_next;
        dir       <= dir_next;
        speed     <= speed_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_status     <= cmd.status;
      scan_active     <= scan_next;
      drive_direction <= dir_next;
      drive_speed     <= speed_next;
      move_restart    <= cmd.restart;
    end
  end

endmodule

// ===== rtl/fixed_frame_command_decoder.sv =====
// Top level of the fixed-frame command decoder: front end, command FIFO, executor.
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+-------------------------
//   input   | in_valid, in_stall, rx_byte      | in_valid && !in_stall
//   output  | out_valid, out_stall, line_status,| out_valid && !out_stall
//           | scan_active, drive_direction,    |
//           | drive_speed, move_restart        |
//
// One byte is taken per cycle unless in_stall is high. A newline transfer writes the FIFO at
// its own edge; the result then goes out via the executor register once the output is free.
// rst (synchronous, active high) clears line length, FIFO pointers, state and out_valid;
// the line store needs no clearing, so the block takes bytes right after reset.
// in_stall is high only while the two-entry command FIFO is full; out_stall backs up
// the executor, then the FIFO, then the input.
module fixed_frame_command_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           line_status,
  output logic                                 scan_active,
  output logic [ffcd_pkg::DIR_W-1:0]           drive_direction,
  output logic signed [ffcd_pkg::SPEED_W-1:0]  drive_speed,
  output logic                                 move_restart
);
  import ffcd_pkg::*;

  // front end -> FIFO
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // FIFO -> executor
  logic q_pop;
  logic q_empty;
  cmd_t q_pop_cmd;

  // Collects bytes, drops CR, classifies the line on newline.
  ffcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  // Decouples line classification from result delivery.
  ffcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (q_pop_cmd)
  );

  // Holds scanner/drive state; output register doubles as the result buffer.
  ffcd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .cmd             (q_pop_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_status     (line_status),
    .scan_active     (scan_active),
    .drive_direction (drive_direction),
    .drive_speed     (drive_speed),
    .move_restart    (move_restart)
  );

endmodule
